FILE: rtl/stbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted table search block.
// No dependencies; imported by the interfaces, datapath, controller and top level.
package stbs_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic table_empty;
    logic probe_hit;
    logic probe_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/stbs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on stbs_pkg for field widths.
interface stbs_in_if import stbs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface stbs_out_if import stbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

FILE: rtl/stbs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/stbs_dp.sv
`timescale 1ns / 1ps
// Datapath: entry count, table RAM, search bounds, probe compare, result register.
// Depends on stbs_pkg and stbs_ram.
module stbs_dp import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_position
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             low_r, low_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic [CW-1:0]             mid_r, mid_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic                      hit_r, hit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      found_r, found_nxt;
  logic [POS_W-1:0]          position_r, position_nxt;

  logic [VALUE_W-1:0]        rdata;
  logic signed [VALUE_W-1:0] probe;
  logic                      eq, lt, not_full;
  logic [CW-1:0]             low_step, hi_step, mid_step, mid_start;
  logic [AW-1:0]             raddr;

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append && not_full),
    .waddr (count_r[AW-1:0]),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    probe     = $signed(rdata);
    eq        = (probe == key_r);
    lt        = (probe < key_r);
    not_full  = (count_r < CW'(TABLE_DEPTH));
    low_step  = lt ? (mid_r + CW'(1)) : low_r;
    hi_step   = lt ? hi_r : mid_r;
    mid_step  = low_step + ((hi_step - low_step - CW'(1)) >> 1);
    mid_start = (count_r - CW'(1)) >> 1;
    raddr     = cmd.start ? mid_start[AW-1:0] : mid_step[AW-1:0];

    status.table_empty = (count_r == '0);
    status.probe_hit   = eq;
    status.probe_last  = !eq && !(low_step < hi_step);
    status.out_free    = !out_valid_r || out_ready;

    count_nxt     = count_r;
    low_nxt       = low_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    position_nxt  = position_r;

    if (cmd.clear) begin
      count_nxt = '0;
    end
    if (cmd.append && not_full) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.start) begin
      low_nxt = '0;
      hi_nxt  = count_r;
      mid_nxt = mid_start;
      key_nxt = value;
      hit_nxt = 1'b0;
    end
    if (cmd.step) begin
      hit_nxt = eq;
      if (!eq) begin
        low_nxt = low_step;
        hi_nxt  = hi_step;
        mid_nxt = mid_step;
      end
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      found_nxt     = hit_r;
      position_nxt  = hit_r ? POS_W'(mid_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r      <= low_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    position_r <= position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = found_r;
  assign out_position = position_r;

endmodule

FILE: rtl/stbs_ctrl.sv
`timescale 1ns / 1ps
// Controller: decodes requests and sequences the probe loop and result hand-off.
// Depends on stbs_pkg.
module stbs_ctrl import stbs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  status_t         status,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op_t'(in_op))
            OP_CLEAR:  cmd.clear = 1'b1;
            OP_APPEND: cmd.append = 1'b1;
            OP_SEARCH: begin
              cmd.start = 1'b1;
              state_nxt = status.table_empty ? ST_EMIT : ST_PROBE;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        cmd.step = 1'b1;
        if (status.probe_hit || status.probe_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Sorted table with iterative binary search. Clear and append requests complete in the
// idle state. A search makes up to floor(log2(TABLE_DEPTH))+1 probes, i.e. 9 for 256
// entries and none for an empty table (the table RAM read port sets one probe per cycle),
// then emits once the output is free; the result is valid the cycle after emit.
// Reset clears the entry count and result valid; table contents stay undefined.
module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  stbs_in_if.sink     in_ch,
  stbs_out_if.source  out_ch
);

  cmd_t    cmd;
  status_t status;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .value        (in_ch.value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_found    (out_ch.found),
    .out_position (out_ch.position)
  );

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result overwritten before taken");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ch.ready)
    else $error("request accepted during probe");

  a_search_probes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_SEARCH && !status.table_empty)
      |=> cmd.step)
    else $error("search did not start probing");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.position == '0))
    else $error("miss reported with nonzero position");

endmodule
